>>> sv/ldc_pkg.sv
package ldc_pkg;

    localparam int MAX_LEN    = 64;
    localparam int ADDR_W     = $clog2(MAX_LEN);
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int VAL_W      = $clog2(MAX_LEN + 2);
    localparam int DIST_W     = 7;
    localparam int DIST_MAX   = 127;
    localparam int UNIT_W     = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        ACT_FIRST   = 2'd0,
        ACT_SECOND  = 2'd1,
        ACT_COMPUTE = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]        action;
        logic [UNIT_W-1:0] code_unit;
    } t_ld_req;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } t_ld_res;

    typedef enum logic [1:0] {
        CMD_FIRST,
        CMD_SECOND,
        CMD_COMPUTE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [UNIT_W-1:0] code_unit;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_push;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ROW,
        S_CELL,
        S_DONE
    } t_back_state;

    function automatic logic [DIST_W-1:0] sat_dist(input logic [VAL_W-1:0] v);
        if (32'(v) > DIST_MAX) begin
            return DIST_W'(DIST_MAX);
        end
        return DIST_W'(v);
    endfunction

endpackage

>>> sv/levenshtein_distance_core.sv
// Append requests are taken by the back end when it is idle; the front end takes one request
// per cycle unless its register is held by a full queue. A compute request runs one score
// cell per cycle over the score row, which has one read and one write port, with a setup
// state before each row; if either string is empty it goes straight to the result. A request
// passes through the front register and the command queue before it reaches the back end.
// Synchronous active-low reset clears lengths, overflow, queue and output valid;
// string and score memories are left unset.
module levenshtein_distance_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ldc_pkg::t_ld_req i_in_req,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output ldc_pkg::t_ld_res o_out_res,
    input  logic             i_out_stall
);
    import ldc_pkg::*;

    t_push w_push;
    logic  w_full;
    logic  w_empty;
    logic  w_pop;
    t_cmd  w_cmd;

    ldc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_req    (i_in_req),
        .o_in_stall  (o_in_stall),
        .i_fifo_full (w_full),
        .o_push      (w_push)
    );

    ldc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd),
        .o_empty (w_empty)
    );

    ldc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res),
        .i_out_stall (i_out_stall)
    );

endmodule

>>> sv/ldc_front.sv
module ldc_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ldc_pkg::t_ld_req i_in_req,
    output logic             o_in_stall,
    input  logic             i_fifo_full,
    output ldc_pkg::t_push   o_push
);
    import ldc_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    logic  w_push;
    logic  w_take;
    logic  w_keep;

    assign w_push     = r_valid && !i_fifo_full;
    assign o_in_stall = r_valid && i_fifo_full;
    assign w_take     = i_in_valid && !o_in_stall;
    assign w_keep     = (t_action'(i_in_req.action) != ACT_NONE);

    always_comb begin
        n_valid = r_valid && !w_push;
        n_cmd   = r_cmd;
        if (w_take) begin
            n_valid         = w_keep;
            n_cmd.code_unit = i_in_req.code_unit;
            case (t_action'(i_in_req.action))
                ACT_FIRST:   n_cmd.kind = CMD_FIRST;
                ACT_SECOND:  n_cmd.kind = CMD_SECOND;
                ACT_COMPUTE: n_cmd.kind = CMD_COMPUTE;
                default:     n_cmd.kind = CMD_COMPUTE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

    assign o_push.push = w_push;
    assign o_push.cmd  = r_cmd;

endmodule

>>> sv/ldc_fifo.sv
module ldc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ldc_pkg::t_push i_push,
    output logic          o_full,
    input  logic          i_pop,
    output ldc_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import ldc_pkg::*;

    t_cmd                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr;
    logic [FIFO_PTR_W-1:0] r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  w_wr;
    logic                  w_rd;

    assign o_full  = (r_count == FIFO_CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push.push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + FIFO_PTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + FIFO_PTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + FIFO_CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - FIFO_CNT_W'(1);
            end
        end
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

endmodule

>>> sv/ldc_back.sv
module ldc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ldc_pkg::t_cmd    i_cmd,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    output ldc_pkg::t_ld_res o_out_res,
    input  logic             i_out_stall
);
    import ldc_pkg::*;

    t_back_state r_state;
    t_back_state n_state;

    logic [UNIT_W-1:0] r_first_text  [MAX_LEN];
    logic [UNIT_W-1:0] r_second_text [MAX_LEN];
    logic [VAL_W-1:0]  r_row         [MAX_LEN];
    logic [UNIT_W-1:0] r_ft_q;
    logic [UNIT_W-1:0] r_st_q;
    logic [VAL_W-1:0]  r_row_q;

    logic [LEN_W-1:0]  r_first_len;
    logic [LEN_W-1:0]  r_second_len;
    logic              r_ovf;
    logic [LEN_W-1:0]  r_i;
    logic [LEN_W-1:0]  r_j;
    logic [VAL_W-1:0]  r_left;
    logic [VAL_W-1:0]  r_diag;
    logic [VAL_W-1:0]  r_dist;
    logic              r_out_valid;
    t_ld_res           r_out;

    logic              w_take_cmd;
    logic              w_load_out;
    logic [ADDR_W-1:0] w_ft_ra;
    logic [ADDR_W-1:0] w_col_ra;
    logic [LEN_W-1:0]  w_i_m1;
    logic [LEN_W-1:0]  w_j_m1;
    logic              w_lens_zero;
    logic              w_row_end;
    logic              w_last_row;
    logic [VAL_W-1:0]  w_up;
    logic [VAL_W-1:0]  w_a;
    logic [VAL_W-1:0]  w_b;
    logic [VAL_W-1:0]  w_c;
    logic [VAL_W-1:0]  w_val;

    assign w_i_m1      = r_i - LEN_W'(1);
    assign w_j_m1      = r_j - LEN_W'(1);
    assign w_lens_zero = (r_first_len == '0) || (r_second_len == '0);
    assign w_row_end   = (r_j == r_second_len);
    assign w_last_row  = (r_i == r_first_len);

    assign w_up  = (r_i == LEN_W'(1)) ? VAL_W'(r_j) : r_row_q;
    assign w_a   = r_left + VAL_W'(1);
    assign w_b   = w_up + VAL_W'(1);
    assign w_c   = r_diag + VAL_W'(r_ft_q != r_st_q);

    always_comb begin
        w_val = (w_a < w_b) ? w_a : w_b;
        if (w_c < w_val) begin
            w_val = w_c;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_empty && i_cmd.kind == CMD_COMPUTE) begin
                    n_state = w_lens_zero ? S_DONE : S_ROW;
                end
            end
            S_ROW:  n_state = S_CELL;
            S_CELL: begin
                if (w_row_end) begin
                    n_state = w_last_row ? S_DONE : S_ROW;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_take_cmd = 1'b0;
        w_load_out = 1'b0;
        w_ft_ra    = w_i_m1[ADDR_W-1:0];
        w_col_ra   = '0;
        case (r_state)
            S_IDLE: w_take_cmd = !i_empty;
            S_ROW:  w_col_ra   = '0;
            S_CELL: w_col_ra   = r_j[ADDR_W-1:0];
            S_DONE: w_load_out = !r_out_valid || !i_out_stall;
            default: w_take_cmd = 1'b0;
        endcase
    end

    assign o_pop = w_take_cmd;

    always_ff @(posedge i_clk) begin
        if (w_take_cmd && i_cmd.kind == CMD_FIRST && r_first_len < LEN_W'(MAX_LEN)) begin
            r_first_text[r_first_len[ADDR_W-1:0]] <= i_cmd.code_unit;
        end
        if (w_take_cmd && i_cmd.kind == CMD_SECOND && r_second_len < LEN_W'(MAX_LEN)) begin
            r_second_text[r_second_len[ADDR_W-1:0]] <= i_cmd.code_unit;
        end
        if (r_state == S_CELL) begin
            r_row[w_j_m1[ADDR_W-1:0]] <= w_val;
        end
        r_ft_q  <= r_first_text[w_ft_ra];
        r_st_q  <= r_second_text[w_col_ra];
        r_row_q <= r_row[w_col_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_first_len  <= '0;
            r_second_len <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_take_cmd) begin
                case (i_cmd.kind)
                    CMD_FIRST: begin
                        if (r_first_len < LEN_W'(MAX_LEN)) begin
                            r_first_len <= r_first_len + LEN_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    CMD_SECOND: begin
                        if (r_second_len < LEN_W'(MAX_LEN)) begin
                            r_second_len <= r_second_len + LEN_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (w_load_out) begin
                r_out_valid  <= 1'b1;
                r_first_len  <= '0;
                r_second_len <= '0;
                r_ovf        <= 1'b0;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take_cmd && i_cmd.kind == CMD_COMPUTE) begin
            r_i    <= LEN_W'(1);
            r_dist <= (r_first_len == '0) ? VAL_W'(r_second_len) : VAL_W'(r_first_len);
        end
        if (r_state == S_ROW) begin
            r_j    <= LEN_W'(1);
            r_left <= VAL_W'(r_i);
            r_diag <= VAL_W'(w_i_m1);
        end
        if (r_state == S_CELL) begin
            r_left <= w_val;
            r_diag <= w_up;
            r_j    <= r_j + LEN_W'(1);
            if (w_row_end) begin
                r_i    <= r_i + LEN_W'(1);
                r_dist <= w_val;
            end
        end
        if (w_load_out) begin
            r_out.distance <= sat_dist(r_dist);
            r_out.overflow <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule
